// ===== hdl/fitness_rank_roulette_select_macros.svh =====
// assertion macros shared by the selection engine
`ifndef FITNESS_RANK_ROULETTE_SELECT_MACROS_SVH
`define FITNESS_RANK_ROULETTE_SELECT_MACROS_SVH

// implication checked every clock edge outside reset
`define FRRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication outside reset
`define FRRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/frrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frrs_pkg
// shared types and constants of the rank and roulette selection engine
// ----------------------------------------------------------------------------
package frrs_pkg;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_RANK = 2'd1;
    localparam logic [1:0] FUNC_PAIR = 2'd2;
    localparam logic [1:0] FUNC_ONE  = 2'd3;

    localparam logic CFG_COMPARE_AVERAGE = 1'b0;
    localparam logic CFG_MEMBERS_IN_USE  = 1'b1;

    // empty member average, -100000 in q24.8
    localparam logic signed [31:0] EMPTY_AVERAGE = -32'sd25600000;

    localparam int KEY_W = 32;
    localparam int WEIGHT_W = 40;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

endpackage

// ===== hdl/frrs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frrs_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module frrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/fitness_rank_roulette_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitness_rank_roulette_select
// genetic-algorithm ranking and roulette wheel selection over a population
// ----------------------------------------------------------------------------
// channel   direction  handshake          words
// in        sink       in_valid/in_stall  load, rank, select pair, select one
// out       source     out_valid/out_stall ranked entries or one selection
// cfg       sink       cfg_valid/cfg_ready register index and data
//
// load: restoring divide (one quotient bit a cycle over the 40-bit
//   magnitude), then one key write
// rank: insertion sort over the key memory, then the floor key (key of
//   the last ranked member) is read, then the weights are built and the
//   ranked words emitted
// select: a linear scan compares one cumulative weight at a time for
//   each draw (two draws for a pair), then fetches the ids and key
// reset clears control state, ranked ids to identity and weights to zero
//   (one valid bit per id entry, one for the weights); key memories are
//   undefined until loaded
// out_stall holds the current word; the sequencer waits on it
// ----------------------------------------------------------------------------
`include "fitness_rank_roulette_select_macros.svh"

module fitness_rank_roulette_select #(
    parameter int POP_SIZE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [5:0]  member_index,
    input  logic signed [39:0] score_sum,
    input  logic [7:0]  score_count,
    input  logic signed [31:0] max_score,
    input  logic [15:0] random_a,
    input  logic [15:0] random_b,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [5:0]  rank_position,
    output logic [5:0]  member_id,
    output logic signed [31:0] key_score,
    output logic [5:0]  second_member_id,
    output logic        last,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int AW = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;
    localparam int CW = AW + 1;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DIV      = 5'd1;
    localparam logic [4:0] S_DIVEND   = 5'd2;
    localparam logic [4:0] S_RK_INIT  = 5'd3;
    localparam logic [4:0] S_RK_RDK   = 5'd4;
    localparam logic [4:0] S_RK_WK    = 5'd5;
    localparam logic [4:0] S_RK_RDJ   = 5'd6;
    localparam logic [4:0] S_RK_WJ    = 5'd7;
    localparam logic [4:0] S_RK_CMP   = 5'd8;
    localparam logic [4:0] S_FL_RD    = 5'd9;
    localparam logic [4:0] S_FL_WAIT  = 5'd10;
    localparam logic [4:0] S_CW_RD    = 5'd11;
    localparam logic [4:0] S_CW_WAIT  = 5'd12;
    localparam logic [4:0] S_CW_ACC   = 5'd13;
    localparam logic [4:0] S_EM_RD    = 5'd14;
    localparam logic [4:0] S_EM_WAIT  = 5'd15;
    localparam logic [4:0] S_EM_OUT   = 5'd16;
    localparam logic [4:0] S_SEL_SCAN = 5'd17;
    localparam logic [4:0] S_SEL_ID   = 5'd18;
    localparam logic [4:0] S_SEL_WAIT = 5'd19;
    localparam logic [4:0] S_SEL_KEY  = 5'd20;
    localparam logic [4:0] S_SEL_OUT  = 5'd21;
    localparam logic [4:0] S_OUT      = 5'd22;
    localparam logic [4:0] S_MUL      = 5'd23;

    // floor read reuses the selection key path, tagged with the load code
    // since a load never reaches that state
    localparam logic [1:0] FUNC_FLOOR = frrs_pkg::FUNC_LOAD;

    logic [4:0] state_reg;

    // configuration registers
    logic       cmp_avg_reg;
    logic [6:0] members_reg;

    assign cfg_ready = (state_reg == S_IDLE) && !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_avg_reg <= 1'b1;
            members_reg <= 7'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                frrs_pkg::CFG_COMPARE_AVERAGE: cmp_avg_reg <= cfg_data[0];
                frrs_pkg::CFG_MEMBERS_IN_USE:  members_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamped count of active members
    logic [CW-1:0] active_n;
    always_comb
    begin
        if (members_reg < 7'd2)
        begin
            active_n = CW'(2);
        end
        else if ({25'd0, members_reg} > 32'(POP_SIZE))
        begin
            active_n = CW'(POP_SIZE);
        end
        else
        begin
            active_n = CW'(members_reg);
        end
    end

    // key memories (avg and max), read at one address
    logic          key_we;
    logic [AW-1:0] key_waddr;
    logic [AW-1:0] key_raddr;
    logic [31:0]   avg_wdata;
    logic [31:0]   avg_rdata;
    logic [31:0]   max_rdata;
    logic [31:0]   max_wdata_reg;

    frrs_ram #(.WIDTH(32), .DEPTH(POP_SIZE)) u_avg_ram (
        .clk(clk), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(avg_wdata),
        .rd_addr(key_raddr), .rd_data(avg_rdata)
    );
    frrs_ram #(.WIDTH(32), .DEPTH(POP_SIZE)) u_max_ram (
        .clk(clk), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(max_wdata_reg),
        .rd_addr(key_raddr), .rd_data(max_rdata)
    );
    frrs_pkg::key_t key_rd;
    assign key_rd = cmp_avg_reg ? avg_rdata : max_rdata;

    // ranked ids memory with per-entry valid bits (identity at reset)
    logic          id_we;
    logic [AW-1:0] id_waddr;
    logic [AW-1:0] id_wdata;
    logic [AW-1:0] id_raddr;
    logic [AW-1:0] id_ram_q;
    logic [AW-1:0] id_raddr_q;
    logic [POP_SIZE-1:0] id_vld_reg;
    logic [AW-1:0] id_rd;

    frrs_ram #(.WIDTH(AW), .DEPTH(POP_SIZE)) u_id_ram (
        .clk(clk), .wr_en(id_we), .wr_addr(id_waddr), .wr_data(id_wdata),
        .rd_addr(id_raddr), .rd_data(id_ram_q)
    );
    assign id_rd = id_vld_reg[id_raddr_q] ? id_ram_q : id_raddr_q;

    // cumulative weight memory, zero until the first rank
    logic                  cw_we;
    logic [AW-1:0]         cw_waddr;
    frrs_pkg::weight_t     cw_wdata;
    logic [AW-1:0]         cw_raddr;
    frrs_pkg::weight_t     cw_q;
    logic                  cw_vld_reg;
    frrs_pkg::weight_t     cw_rd;

    frrs_ram #(.WIDTH(frrs_pkg::WEIGHT_W), .DEPTH(POP_SIZE)) u_cw_ram (
        .clk(clk), .wr_en(cw_we), .wr_addr(cw_waddr), .wr_data(cw_wdata),
        .rd_addr(cw_raddr), .rd_data(cw_q)
    );
    assign cw_rd = cw_vld_reg ? cw_q : '0;

    // sequencer registers
    logic [1:0]    func_reg;
    logic [AW-1:0] slot_reg;
    logic [39:0]   mag_reg;       // dividend, shifts into quotient
    logic [7:0]    div_reg;
    logic [8:0]    rem_reg;
    logic          neg_reg;
    logic [5:0]    bit_cnt_reg;
    logic          empty_reg;
    logic [CW-1:0] i_reg;
    logic [AW-1:0] j_reg;
    frrs_pkg::key_t k_reg;
    logic [AW-1:0] idj_reg;
    frrs_pkg::key_t floor_reg;
    frrs_pkg::weight_t acc_reg;
    frrs_pkg::weight_t total_reg;
    logic [CW-1:0] ranked_n_reg;
    logic [15:0]   r_b_reg;
    logic          second_reg;    // scanning second draw
    logic [AW-1:0] a_idx_reg;
    logic [AW-1:0] b_idx_reg;
    logic [55:0]   prod_reg;
    logic [AW-1:0] a_id_reg;

    // output word registers
    logic          out_valid_reg;
    logic          o_kind_reg;
    logic [5:0]    o_pos_reg;
    logic [5:0]    o_id_reg;
    logic [31:0]   o_key_reg;
    logic [5:0]    o_sec_reg;
    logic          o_last_reg;

    assign out_valid        = out_valid_reg;
    assign result_kind      = o_kind_reg;
    assign rank_position    = o_pos_reg;
    assign member_id        = o_id_reg;
    assign key_score        = o_key_reg;
    assign second_member_id = o_sec_reg;
    assign last             = o_last_reg;

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;

    // divider step: restoring subtract
    logic [8:0]  rem_shift;
    logic [9:0]  rem_sub;
    assign rem_shift = {rem_reg[7:0], mag_reg[39]};
    assign rem_sub   = {1'b0, rem_shift} - {2'b00, div_reg};

    // saturated signed average
    logic [31:0] avg_sat;
    always_comb
    begin
        if (empty_reg)
        begin
            avg_sat = frrs_pkg::EMPTY_AVERAGE;
        end
        else if (neg_reg)
        begin
            avg_sat = (mag_reg > 40'h0080000000) ? 32'h80000000 : (~mag_reg[31:0] + 32'd1);
        end
        else
        begin
            avg_sat = (mag_reg > 40'h007FFFFFFF) ? 32'h7FFFFFFF : mag_reg[31:0];
        end
    end
    assign avg_wdata = avg_sat;

    // weight of the current ranked key
    logic signed [32:0] w_diff;
    assign w_diff = 33'(key_rd) - 33'(floor_reg);

    logic [CW-1:0] last_rank;
    assign last_rank = ranked_n_reg - CW'(1);

    // cumulative weight compare uses the product r * total held in prod_reg
    logic [55:0] cw_scaled;
    assign cw_scaled = {cw_rd, 16'd0};

    always_comb
    begin
        key_we = 1'b0;
        key_waddr = slot_reg;
        key_raddr = '0;
        id_we = 1'b0;
        id_waddr = j_reg;
        id_wdata = idj_reg;
        id_raddr = '0;
        cw_we = 1'b0;
        cw_waddr = i_reg[AW-1:0];
        cw_wdata = acc_reg;
        cw_raddr = i_reg[AW-1:0];
        case (state_reg)
            S_DIVEND:
            begin
                key_we = 1'b1;
            end
            S_RK_INIT, S_RK_RDK:
            begin
                key_raddr = i_reg[AW-1:0];
            end
            S_RK_RDJ:
            begin
                id_raddr = j_reg - AW'(1);
            end
            S_RK_WJ:
            begin
                key_raddr = id_rd;
            end
            S_RK_CMP:
            begin
                if (j_reg != '0 && key_rd < k_reg)
                begin
                    id_we = 1'b1;
                end
                else
                begin
                    id_we = 1'b1;
                    id_wdata = i_reg[AW-1:0];
                end
            end
            S_FL_RD:
            begin
                id_raddr = last_rank[AW-1:0];
            end
            S_FL_WAIT:
            begin
                key_raddr = id_rd;
            end
            S_CW_RD, S_EM_RD:
            begin
                id_raddr = i_reg[AW-1:0];
            end
            S_CW_WAIT, S_EM_WAIT:
            begin
                key_raddr = id_rd;
            end
            S_CW_ACC:
            begin
                cw_we = 1'b1;
                cw_wdata = acc_reg + (w_diff[32] ? '0 : frrs_pkg::weight_t'(w_diff));
            end
            S_SEL_ID:
            begin
                id_raddr = a_idx_reg;
            end
            S_SEL_WAIT:
            begin
                key_raddr = id_rd;
            end
            // second id held on the read port until the word goes out
            S_SEL_KEY, S_SEL_OUT:
            begin
                id_raddr = b_idx_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            id_vld_reg    <= '0;
            cw_vld_reg    <= 1'b0;
            total_reg     <= '0;
            ranked_n_reg  <= CW'(POP_SIZE < 32 ? POP_SIZE : 32);
            id_raddr_q    <= '0;
        end
        else
        begin
            id_raddr_q <= id_raddr;
            if (id_we)
            begin
                id_vld_reg[id_waddr] <= 1'b1;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        func_reg <= func;
                        r_b_reg  <= random_b;
                        case (func)
                            frrs_pkg::FUNC_LOAD:
                            begin
                                if ({26'd0, member_index} < 32'(POP_SIZE))
                                begin
                                    slot_reg <= member_index[AW-1:0];
                                    max_wdata_reg <= max_score;
                                    neg_reg <= score_sum[39];
                                    mag_reg <= score_sum[39] ? (40'd0 - score_sum) : score_sum;
                                    div_reg <= score_count;
                                    empty_reg <= (score_count == 8'd0);
                                    rem_reg <= '0;
                                    bit_cnt_reg <= 6'd40;
                                    state_reg <= S_DIV;
                                end
                            end
                            frrs_pkg::FUNC_RANK:
                            begin
                                i_reg <= '0;
                                ranked_n_reg <= active_n;
                                state_reg <= S_RK_INIT;
                            end
                            default:
                            begin
                                second_reg <= 1'b0;
                                i_reg <= '0;
                                prod_reg <= 56'(random_a) * 56'(total_reg);
                                state_reg <= S_MUL;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (rem_sub[9])
                    begin
                        rem_reg <= rem_shift;
                        mag_reg <= {mag_reg[38:0], 1'b0};
                    end
                    else
                    begin
                        rem_reg <= rem_sub[8:0];
                        mag_reg <= {mag_reg[38:0], 1'b1};
                    end
                    bit_cnt_reg <= bit_cnt_reg - 6'd1;
                    if (bit_cnt_reg == 6'd1)
                    begin
                        state_reg <= S_DIVEND;
                    end
                end
                S_DIVEND:
                begin
                    state_reg <= S_IDLE;
                end
                // insertion sort, one element per outer step
                S_RK_INIT:
                begin
                    state_reg <= S_RK_RDK;
                end
                S_RK_RDK:
                begin
                    k_reg <= key_rd;
                    j_reg <= i_reg[AW-1:0];
                    state_reg <= S_RK_WK;
                end
                S_RK_WK:
                begin
                    state_reg <= S_RK_RDJ;
                end
                S_RK_RDJ:
                begin
                    state_reg <= S_RK_WJ;
                end
                S_RK_WJ:
                begin
                    idj_reg <= id_rd;
                    state_reg <= S_RK_CMP;
                end
                S_RK_CMP:
                begin
                    if (j_reg != '0 && key_rd < k_reg)
                    begin
                        j_reg <= j_reg - AW'(1);
                        state_reg <= S_RK_RDJ;
                    end
                    else if (i_reg + CW'(1) < ranked_n_reg)
                    begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= S_RK_INIT;
                    end
                    else
                    begin
                        state_reg <= S_FL_RD;
                    end
                end
                S_FL_RD:
                begin
                    state_reg <= S_FL_WAIT;
                end
                // key of the last ranked member arrives in the key state
                S_FL_WAIT:
                begin
                    state_reg <= S_SEL_KEY;
                    func_reg <= FUNC_FLOOR;
                end
                S_CW_RD:
                begin
                    state_reg <= S_CW_WAIT;
                end
                S_CW_WAIT:
                begin
                    state_reg <= S_CW_ACC;
                end
                S_CW_ACC:
                begin
                    acc_reg <= cw_wdata;
                    if (i_reg == last_rank)
                    begin
                        total_reg <= cw_wdata;
                        cw_vld_reg <= 1'b1;
                        i_reg <= '0;
                        state_reg <= S_EM_RD;
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= S_CW_RD;
                    end
                end
                S_EM_RD:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= S_EM_WAIT;
                    end
                end
                S_EM_WAIT:
                begin
                    state_reg <= S_EM_OUT;
                end
                S_EM_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    o_kind_reg <= 1'b0;
                    o_pos_reg  <= 6'(i_reg);
                    o_id_reg   <= 6'(idj_reg);
                    o_key_reg  <= key_rd;
                    o_sec_reg  <= '0;
                    o_last_reg <= (i_reg == last_rank);
                    if (i_reg == last_rank)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= S_EM_RD;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_SEL_SCAN;
                end
                // linear scan of the cumulative distribution
                S_SEL_SCAN:
                begin
                    if (total_reg == '0 || i_reg == last_rank || cw_scaled >= prod_reg)
                    begin
                        if (!second_reg)
                        begin
                            a_idx_reg <= (total_reg == '0) ? '0 : i_reg[AW-1:0];
                            if (func_reg == frrs_pkg::FUNC_PAIR)
                            begin
                                second_reg <= 1'b1;
                                i_reg <= '0;
                                prod_reg <= 56'(r_b_reg) * 56'(total_reg);
                                state_reg <= S_MUL;
                            end
                            else
                            begin
                                b_idx_reg <= '0;
                                state_reg <= S_SEL_ID;
                            end
                        end
                        else
                        begin
                            b_idx_reg <= (total_reg == '0) ? '0 : i_reg[AW-1:0];
                            state_reg <= S_SEL_ID;
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                        state_reg <= S_MUL;
                    end
                end
                S_SEL_ID:
                begin
                    if (func_reg == frrs_pkg::FUNC_PAIR && a_idx_reg == b_idx_reg)
                    begin
                        b_idx_reg <= (b_idx_reg == '0) ? AW'(1) : b_idx_reg - AW'(1);
                    end
                    state_reg <= S_SEL_WAIT;
                end
                S_SEL_WAIT:
                begin
                    a_id_reg <= id_rd;
                    state_reg <= S_SEL_KEY;
                end
                S_SEL_KEY:
                begin
                    if (func_reg == FUNC_FLOOR)
                    begin
                        floor_reg <= key_rd;
                        acc_reg <= '0;
                        i_reg <= '0;
                        func_reg <= frrs_pkg::FUNC_RANK;
                        state_reg <= S_CW_RD;
                    end
                    else
                    begin
                        k_reg <= key_rd;
                        state_reg <= S_SEL_OUT;
                    end
                end
                // waits for an empty output register
                S_SEL_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        o_kind_reg <= 1'b1;
                        o_pos_reg  <= 6'(a_idx_reg);
                        o_id_reg   <= 6'(a_id_reg);
                        o_key_reg  <= k_reg;
                        o_sec_reg  <= (func_reg == frrs_pkg::FUNC_PAIR) ? 6'(id_rd) : 6'd0;
                        o_last_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (state_reg == S_EM_WAIT)
            begin
                idj_reg <= id_rd;
            end
        end
    end

    `FRRS_ASSERT_IMP(a_stall_busy, clk, rst_n, state_reg != S_IDLE, in_stall)
    `FRRS_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_ready, state_reg == S_IDLE)
    `FRRS_ASSERT_NEXT(a_load_quiet, clk, rst_n,
        state_reg == S_DIVEND, !out_valid || $stable(o_last_reg))
    `FRRS_ASSERT_IMP(a_sel_last, clk, rst_n, out_valid && result_kind, last)

endmodule

// ===== verif/fitness_rank_roulette_select_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fitness_rank_roulette_select_tb
// self-checking bench for the rank and roulette selection engine: loads,
// ranks and selections under several register settings, with random gaps and
// output stalls, checked word by word against a built-in selection predictor
// ----------------------------------------------------------------------------
module fitness_rank_roulette_select_tb;

    localparam int SLOTS = 32;
    localparam int CYCLE_LIMIT = 1000000;
    // loads give no word, so wait this long when idle
    localparam int SETTLE = 120;

    typedef struct {
        logic [1:0]         func;
        logic [5:0]         member_index;
        logic signed [39:0] score_sum;
        logic [7:0]         score_count;
        logic signed [31:0] max_score;
        logic [15:0]        random_a;
        logic [15:0]        random_b;
    } job_t;

    typedef struct packed {
        logic           kind;
        logic [5:0]     pos;
        logic [5:0]     id;
        frrs_pkg::key_t key;
        logic [5:0]     second;
        logic           last;
    } pick_t;

    // selection predictor plus queue of expected output words
    class sel_scoreboard;
        bit              cmp_avg;
        int unsigned     members;
        frrs_pkg::key_t  avg_key [SLOTS];
        frrs_pkg::key_t  best_key [SLOTS];
        int unsigned     order [SLOTS];
        longint unsigned cum [SLOTS];
        longint unsigned total;
        int unsigned     order_n;
        pick_t           pending [$];
        int              errors;
        int              checked;

        function new();
            cmp_avg = 1;
            members = 32;
            total = 0;
            order_n = 32;
            errors = 0;
            checked = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                avg_key[i] = 0;
                best_key[i] = 0;
                order[i] = i;
                cum[i] = 0;
            end
        endfunction

        function void set_reg(logic idx, logic [6:0] val);
            if (idx == frrs_pkg::CFG_COMPARE_AVERAGE)
                cmp_avg = val[0];
            else
                members = val;
        endfunction

        function frrs_pkg::key_t key_of(int unsigned id);
            return cmp_avg ? avg_key[id % SLOTS] : best_key[id % SLOTS];
        endfunction

        function int unsigned draw(logic [15:0] r);
            int unsigned i;
            i = 0;
            if (total == 0)
                return 0;
            while (i + 1 < order_n && cum[i] * 65536 < longint'(r) * total)
                i++;
            return i;
        endfunction

        function void push(logic kind, int unsigned pos, int unsigned id,
                           int unsigned second, logic last);
            pick_t p;
            p.kind = kind;
            p.pos = 6'(pos);
            p.id = 6'(id);
            p.key = key_of(id);
            p.second = 6'(second);
            p.last = last;
            pending.insert(pending.size(), p);
        endfunction

        // accepted input word: update state, queue what it causes
        function void note_input(job_t j);
            longint q;
            int unsigned n, k, a, b;
            longint w, floor_key;
            longint unsigned acc;
            frrs_pkg::key_t kk;
            case (j.func)
                frrs_pkg::FUNC_LOAD:
                begin
                    if (j.member_index < SLOTS)
                    begin
                        if (j.score_count == 0)
                            avg_key[j.member_index] = frrs_pkg::EMPTY_AVERAGE;
                        else
                        begin
                            q = longint'(j.score_sum) / longint'(j.score_count);
                            if (q > 64'sd2147483647)
                                q = 64'sd2147483647;
                            if (q < -64'sd2147483648)
                                q = -64'sd2147483648;
                            avg_key[j.member_index] = q[31:0];
                        end
                        best_key[j.member_index] = j.max_score;
                    end
                end
                frrs_pkg::FUNC_RANK:
                begin
                    n = members < 2 ? 2 : (members > SLOTS ? SLOTS : members);
                    // stable insertion sort, descending
                    for (int unsigned i = 0; i < n; i++)
                    begin
                        kk = key_of(i);
                        k = i;
                        while (k > 0 && key_of(order[k - 1]) < kk)
                        begin
                            order[k] = order[k - 1];
                            k--;
                        end
                        order[k] = i;
                    end
                    floor_key = key_of(order[n - 1]);
                    acc = 0;
                    for (int unsigned i = 0; i < SLOTS; i++)
                    begin
                        if (i < n)
                        begin
                            w = longint'(key_of(order[i])) - floor_key;
                            acc += (w < 0) ? 0 : w;
                        end
                        cum[i] = acc;
                    end
                    total = acc;
                    order_n = n;
                    for (int unsigned i = 0; i < n; i++)
                        push(1'b0, i, order[i], 0, i + 1 == n);
                end
                default:
                begin
                    a = draw(j.random_a);
                    if (j.func == frrs_pkg::FUNC_PAIR)
                    begin
                        b = draw(j.random_b);
                        if (a == b)
                            b = (b == 0) ? 1 : b - 1;
                        push(1'b1, a, order[a], order[b % SLOTS], 1'b1);
                    end
                    else
                        push(1'b1, a, order[a], 0, 1'b1);
                end
            endcase
        endfunction

        function void check(pick_t got);
            pick_t e;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word kind=%0d pos=%0d id=%0d", $time,
                         got.kind, got.pos, got.id);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                errors++;
                $display("%0t: mismatch expected kind=%0d pos=%0d id=%0d key=%0d sec=%0d last=%0d",
                         $time, e.kind, e.pos, e.id, e.key, e.second, e.last);
                $display("%0t:          actual   kind=%0d pos=%0d id=%0d key=%0d sec=%0d last=%0d",
                         $time, got.kind, got.pos, got.id, got.key, got.second, got.last);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         func;
    logic [5:0]         member_index;
    logic signed [39:0] score_sum;
    logic [7:0]         score_count;
    logic signed [31:0] max_score;
    logic [15:0]        random_a;
    logic [15:0]        random_b;
    logic               out_valid;
    logic               out_stall;
    logic               result_kind;
    logic [5:0]         rank_position;
    logic [5:0]         member_id;
    logic signed [31:0] key_score;
    logic [5:0]         second_member_id;
    logic               last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [6:0]         cfg_data;

    sel_scoreboard sb;
    int            cycles;
    int            stall_left;
    bit            calm;       // no new output stalls started while set
    int            n_words [4];
    int            n_cfg;

    fitness_rank_roulette_select uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .member_index(member_index), .score_sum(score_sum),
        .score_count(score_count), .max_score(max_score),
        .random_a(random_a), .random_b(random_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .rank_position(rank_position),
        .member_id(member_id), .key_score(key_score),
        .second_member_id(second_member_id), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // output side: random stalls, checks every accepted word
    always @(posedge clk)
    begin
        pick_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.kind = result_kind;
            got.pos = rank_position;
            got.id = member_id;
            got.key = key_score;
            got.second = second_member_id;
            got.last = last;
            sb.check(got);
        end
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            stall_left <= gap_len();
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // generous limit: up to 32 words per item, long stalls and a full sort each
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("fitness_rank_roulette_select_tb: FAIL");
            $finish;
        end
    end

    function automatic job_t mk_load(int idx, logic signed [39:0] sum, int cnt,
                                     logic signed [31:0] mx);
        job_t j;
        j.func = frrs_pkg::FUNC_LOAD;
        j.member_index = 6'(idx);
        j.score_sum = sum;
        j.score_count = 8'(cnt);
        j.max_score = mx;
        j.random_a = 16'($urandom);
        j.random_b = 16'($urandom);
        return j;
    endfunction

    function automatic job_t mk_sel(logic [1:0] f, int a, int b);
        job_t j;
        j = mk_load($urandom_range(0, 63), 40'({$urandom, $urandom}), int'($urandom),
                    $urandom);
        j.func = f;
        j.random_a = 16'(a);
        j.random_b = 16'(b);
        return j;
    endfunction

    // random word, leaning toward loads with clustered scores for ties
    function automatic job_t rand_job();
        job_t j;
        int r;
        logic signed [39:0] sum;
        logic signed [31:0] mx;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            case ($urandom_range(0, 3))
                0: sum = 40'({$urandom, $urandom});
                1: sum = $signed(40'($urandom_range(0, 2000))) - 40'sd1000;
                default: sum = $signed({{8{1'b0}}, 32'($urandom_range(0, 65535))})
                               - 40'sd32768;
            endcase
            mx = ($urandom_range(0, 2) == 0) ? $urandom
                 : 32'($urandom_range(0, 3)) * 32'sd4096 - 32'sd2048;
            return mk_load($urandom_range(0, 63), sum, $urandom_range(0, 255), mx);
        end
        if (r < 55)
            return mk_sel(frrs_pkg::FUNC_RANK, $urandom, $urandom);
        if (r < 78)
            return mk_sel(frrs_pkg::FUNC_PAIR, $urandom, $urandom);
        j = mk_sel(frrs_pkg::FUNC_ONE, $urandom, $urandom);
        return j;
    endfunction

    task automatic send(job_t j);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= j.func;
        member_index <= j.member_index;
        score_sum <= j.score_sum;
        score_count <= j.score_count;
        max_score <= j.max_score;
        random_a <= j.random_a;
        random_b <= j.random_b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(j);
        n_words[j.func]++;
    endtask

    // drop valid and let every pending word drain, then settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        n_cfg++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic phase(logic cmp, logic [6:0] mem, int count);
        drain();
        write_reg(frrs_pkg::CFG_COMPARE_AVERAGE, 7'(cmp));
        write_reg(frrs_pkg::CFG_MEMBERS_IN_USE, mem);
        calm = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < count; i++)
            send(rand_job());
        send(mk_sel(frrs_pkg::FUNC_RANK, 0, 0));
        send(mk_sel(frrs_pkg::FUNC_PAIR, $urandom, $urandom));
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        stall_left = 0;
        calm = 0;
        n_cfg = 0;
        n_words = '{default: 0};
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = frrs_pkg::FUNC_LOAD;
        member_index = '0;
        score_sum = '0;
        score_count = '0;
        max_score = '0;
        random_a = '0;
        random_b = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = frrs_pkg::CFG_COMPARE_AVERAGE;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every slot written first so no key read ever hits an empty slot
        send(mk_load(0, 40'sd1000, 0, 32'sh7fffffff));          // empty average
        send(mk_load(1, 40'sh7fffffffff, 1, -32'sd2147483648)); // high saturation
        send(mk_load(2, -40'sh8000000000, 1, 32'sd0));          // low saturation
        send(mk_load(3, -40'sd7, 2, -32'sd1));                  // truncate toward zero
        send(mk_load(4, 40'sd65535, 255, 32'sd256));
        send(mk_load(63, 40'sd1, 1, 32'sd1));                   // slot past the population
        for (int i = 5; i < SLOTS; i++)
            send(mk_load(i, $signed(40'($urandom_range(0, 100000))) - 40'sd50000,
                         $urandom_range(0, 255), $urandom_range(0, 3) * 1000));
        // selections on the reset distribution, then a rank and selections on the ranked one
        send(mk_sel(frrs_pkg::FUNC_ONE, 16'hffff, 0));
        send(mk_sel(frrs_pkg::FUNC_PAIR, 0, 16'hffff));
        send(mk_sel(frrs_pkg::FUNC_RANK, 0, 0));
        send(mk_sel(frrs_pkg::FUNC_ONE, 0, 0));
        send(mk_sel(frrs_pkg::FUNC_ONE, 16'hffff, 16'hffff));
        send(mk_sel(frrs_pkg::FUNC_PAIR, 16'hffff, 16'hffff)); // same draw twice
        send(mk_sel(frrs_pkg::FUNC_PAIR, 0, 0));

        // maximum keys, two members, equal keys: zero total weight
        drain();
        write_reg(frrs_pkg::CFG_COMPARE_AVERAGE, 7'd0);
        write_reg(frrs_pkg::CFG_MEMBERS_IN_USE, 7'd2);
        send(mk_load(0, 40'sd5, 1, 32'sd12345));
        send(mk_load(1, 40'sd9, 1, 32'sd12345));
        send(mk_sel(frrs_pkg::FUNC_RANK, 0, 0));
        send(mk_sel(frrs_pkg::FUNC_PAIR, 16'h8000, 16'h8000));
        send(mk_sel(frrs_pkg::FUNC_ONE, 16'hffff, 0));

        phase(1'b1, 7'd64, 15);
        phase(1'b0, 7'd0, 10);
        phase(1'b1, 7'd127, 15);
        phase(1'b0, 7'd17, 15);
        phase(1'b1, 7'd5, 10);
        phase(1'b0, 7'd32, 10);

        drain();
        $display("covered %0d loads, %0d ranks, %0d pair and %0d single selections",
                 n_words[frrs_pkg::FUNC_LOAD], n_words[frrs_pkg::FUNC_RANK],
                 n_words[frrs_pkg::FUNC_PAIR], n_words[frrs_pkg::FUNC_ONE]);
        $display("checked %0d output words across %0d register writes, %0d errors",
                 sb.checked, n_cfg, sb.errors);
        if (sb.errors == 0)
            $display("fitness_rank_roulette_select_tb: PASS");
        else
            $display("fitness_rank_roulette_select_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/frrs_pkg.sv
hdl/frrs_ram.sv
hdl/fitness_rank_roulette_select.sv
verif/fitness_rank_roulette_select_tb.sv
